// ===== src/rdr_pkg.sv =====
package rdr_pkg;

    // Signed width of the fraction arithmetic; the low WIDTH bits of each field are used.
    localparam int WIDTH   = 32;
    // Width of the cross products and of the GCD and divider datapaths.
    localparam int PROD_W  = 2 * WIDTH;
    // Bits for a shift or step count over PROD_W positions.
    localparam int CNT_W   = $clog2(PROD_W);
    // Fixed port field widths.
    localparam int FIELD_W = 32;
    localparam int DEN_W   = 31;

    typedef struct packed {
        logic                      req_type;
        logic signed [FIELD_W-1:0] a_num;
        logic signed [FIELD_W-1:0] a_den;
        logic signed [FIELD_W-1:0] b_num;
        logic signed [FIELD_W-1:0] b_den;
    } req_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] res_num;
        logic        [DEN_W-1:0]   res_den;
        logic                      overflow;
    } res_t;

endpackage

// ===== src/rational_divide_reduce_top.sv =====
// Channel   Ports                  Transaction taken when
// --------  ---------------------  -----------------------------------------
// request   start, busy, req       rising edge with start high and busy low
// result    done, result           rising edge that ends the cycle done is high
//
// A request holds busy high from acceptance until its result strobe. The
// binary GCD engine (one shift or subtract a cycle) runs first, then the
// PROD_W-step divider; a division forms both cross products before them. Zero
// numerator or denominator skips both. rst_n clears the sequencer and the
// strobe asynchronously; the receiver cannot stall, so done is high for
// exactly one cycle per result.
module rational_divide_reduce_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rdr_pkg::req_t req,
    output logic          done,
    output rdr_pkg::res_t result
);

    localparam int W  = rdr_pkg::WIDTH;
    localparam int PW = rdr_pkg::PROD_W;
    localparam int FW = rdr_pkg::FIELD_W;
    localparam int DW = rdr_pkg::DEN_W;
    localparam logic [PW-1:0] HALF = PW'(1) << (W - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL0  = 7'b0000010,
        S_MUL1  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_GCD   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t        state_reg, state_next;
    logic          done_reg, done_next;
    rdr_pkg::res_t result_reg, result_next;

    // Operand magnitudes, held for the two cross products.
    logic [W-1:0]  an_reg, an_next, ad_reg, ad_next;
    logic [W-1:0]  bn_reg, bn_next, bd_reg, bd_next;
    // Working numerator and denominator magnitudes, and the result sign.
    logic [PW-1:0] nm_reg, nm_next, dm_reg, dm_next;
    logic          neg_reg, neg_next;

    logic [W-1:0]  mul_a, mul_b;
    logic [PW-1:0] prod;
    logic          gcd_start, gcd_done, div_start, div_done;
    logic [PW-1:0] gcd_g, div_q0, div_q1;
    logic [PW-1:0] num_signed;

    // Magnitude of the low W bits read as two's complement.
    function automatic logic [W-1:0] mag_of(input logic [FW-1:0] v);
        logic [W-1:0] low;
        begin
            low    = v[W-1:0];
            mag_of = low[W-1] ? ({W{1'b0}} - low) : low;
        end
    endfunction

    // Shared multiplier: a_num*b_den first, then a_den*b_num.
    assign mul_a = state_reg == S_MUL0 ? an_reg : ad_reg;
    assign mul_b = state_reg == S_MUL0 ? bd_reg : bn_reg;
    assign prod  = PW'(mul_a) * PW'(mul_b);

    rdr_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .x     (nm_reg),
        .y     (dm_reg),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    rdr_exdiv u_exdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n0    (nm_reg),
        .n1    (dm_reg),
        .d     (gcd_g),
        .done  (div_done),
        .q0    (div_q0),
        .q1    (div_q1)
    );

    // Pack the reduced fraction: apply the sign, flag out-of-range parts, truncate.
    assign num_signed = neg_reg ? ({PW{1'b0}} - nm_reg) : nm_reg;

    always_comb
    begin
        result_next.res_num  = FW'($signed(num_signed[W-1:0]));
        result_next.res_den  = DW'(dm_reg[W-2:0]);
        result_next.overflow = (neg_reg ? (nm_reg > HALF) : (nm_reg > (HALF - 1'b1)))
                               || (dm_reg > (HALF - 1'b1));
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        an_next    = an_reg;
        ad_next    = ad_reg;
        bn_next    = bn_reg;
        bd_next    = bd_reg;
        nm_next    = nm_reg;
        dm_next    = dm_reg;
        neg_next   = neg_reg;
        gcd_start  = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    an_next = mag_of(req.a_num);
                    ad_next = mag_of(req.a_den);
                    bn_next = mag_of(req.b_num);
                    bd_next = mag_of(req.b_den);
                    if (req.req_type)
                    begin
                        // Sign of (a_num*b_den)/(a_den*b_num).
                        neg_next   = req.a_num[W-1] ^ req.a_den[W-1]
                                     ^ req.b_num[W-1] ^ req.b_den[W-1];
                        state_next = S_MUL0;
                    end
                    else
                    begin
                        neg_next   = req.a_num[W-1] ^ req.a_den[W-1];
                        nm_next    = PW'(mag_of(req.a_num));
                        dm_next    = PW'(mag_of(req.a_den));
                        state_next = S_CHECK;
                    end
                end
            end
            S_MUL0:
            begin
                nm_next    = prod;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                dm_next    = prod;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (dm_reg == '0)
                begin
                    // Infinity keeps the sign as +1 or -1; 0/0 stays 0/0.
                    nm_next    = (nm_reg == '0) ? '0 : PW'(1);
                    neg_next   = (nm_reg == '0) ? 1'b0 : neg_reg;
                    state_next = S_OUT;
                end
                else if (nm_reg == '0)
                begin
                    neg_next   = 1'b0;
                    dm_next    = PW'(1);
                    state_next = S_OUT;
                end
                else
                begin
                    gcd_start  = 1'b1;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (gcd_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    nm_next    = div_q0;
                    dm_next    = div_q1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Capture the result and raise done for one cycle.
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        an_reg  <= an_next;
        ad_reg  <= ad_next;
        bn_reg  <= bn_next;
        bd_reg  <= bd_next;
        nm_reg  <= nm_next;
        dm_reg  <= dm_next;
        neg_reg <= neg_next;
        if (state_reg == S_OUT)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/rdr_gcd.sv =====
// Binary GCD engine: one shift or one subtract per cycle.
// Both operands must be nonzero at start.
module rdr_gcd (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rdr_pkg::PROD_W-1:0]  x,
    input  logic [rdr_pkg::PROD_W-1:0]  y,
    output logic                        done,
    output logic [rdr_pkg::PROD_W-1:0]  g
);

    localparam int PW = rdr_pkg::PROD_W;
    localparam int KW = rdr_pkg::CNT_W;

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [PW-1:0] x_reg, x_next;
    logic [PW-1:0] y_reg, y_next;
    logic [KW-1:0] k_reg, k_next;
    logic [PW-1:0] g_reg, g_next;
    logic          x_gt_y;
    logic [PW-1:0] diff;

    // Shared compare and subtract.
    assign x_gt_y = x_reg > y_reg;
    assign diff   = x_gt_y ? (x_reg - y_reg) : (y_reg - x_reg);

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        y_next    = y_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        if (start)
        begin
            run_next = 1'b1;
            x_next   = x;
            y_next   = y;
            k_next   = '0;
        end
        else if (run_reg)
        begin
            if (x_reg == y_reg)
            begin
                // Put back the common power of two and finish.
                g_next    = x_reg << k_reg;
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (x_gt_y)
            begin
                x_next = diff;
            end
            else
            begin
                y_next = diff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        k_reg <= k_next;
        g_reg <= g_next;
    end

    assign done = done_reg;
    assign g    = g_reg;

endmodule

// ===== src/rdr_exdiv.sv =====
// Restoring divider, one quotient bit per cycle, two dividends over one divisor.
module rdr_exdiv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rdr_pkg::PROD_W-1:0]  n0,
    input  logic [rdr_pkg::PROD_W-1:0]  n1,
    input  logic [rdr_pkg::PROD_W-1:0]  d,
    output logic                        done,
    output logic [rdr_pkg::PROD_W-1:0]  q0,
    output logic [rdr_pkg::PROD_W-1:0]  q1
);

    localparam int PW = rdr_pkg::PROD_W;
    localparam int KW = rdr_pkg::CNT_W;

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] d_reg, d_next;
    logic [PW-1:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [PW-1:0] q0_reg, q0_next, q1_reg, q1_next;
    logic [PW-1:0] r0_step, r1_step, q0_step, q1_step;

    // One restoring step of a lane: shift in the next dividend bit, subtract if it fits.
    function automatic logic [2*PW-1:0] div_step(input logic [PW-1:0] r,
                                                  input logic [PW-1:0] q,
                                                  input logic [PW-1:0] dv);
        logic [PW:0]   t;
        logic          fit;
        logic [PW-1:0] r_out;
        begin
            t     = {r, q[PW-1]};
            fit   = t >= {1'b0, dv};
            r_out = fit ? PW'(t - {1'b0, dv}) : t[PW-1:0];
            div_step = {r_out, q[PW-2:0], fit};
        end
    endfunction

    assign {r0_step, q0_step} = div_step(r0_reg, q0_reg, d_reg);
    assign {r1_step, q1_step} = div_step(r1_reg, q1_reg, d_reg);

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        d_next    = d_reg;
        r0_next   = r0_reg;
        r1_next   = r1_reg;
        q0_next   = q0_reg;
        q1_next   = q1_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            d_next   = d;
            r0_next  = '0;
            r1_next  = '0;
            q0_next  = n0;
            q1_next  = n1;
        end
        else if (run_reg)
        begin
            r0_next  = r0_step;
            r1_next  = r1_step;
            q0_next  = q0_step;
            q1_next  = q1_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == KW'(PW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        d_reg   <= d_next;
        r0_reg  <= r0_next;
        r1_reg  <= r1_next;
        q0_reg  <= q0_next;
        q1_reg  <= q1_next;
    end

    assign done = done_reg;
    assign q0   = q0_reg;
    assign q1   = q1_reg;

endmodule
